@@ sv/plob_pkg.sv @@
// plob_pkg: shared types and codes for the price level order book unit.
// No dependencies.
`default_nettype none
package plob_pkg;
  localparam int unsigned QtyW   = 48;
  localparam int unsigned PriceW = 32;
  localparam int unsigned MinW   = 47;
  localparam int unsigned MaxRes = 32;

  typedef enum logic [2:0] {
    CMD_DELTA = 3'd0,
    CMD_SNAP  = 3'd1,
    CMD_SIZE  = 3'd2,
    CMD_SWEEP = 3'd3,
    CMD_RANGE = 3'd4,
    CMD_LIST  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4,
    ST_QUERY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]              cmd;
    logic                    side;
    logic [PriceW-1:0]       price;
    logic [PriceW-1:0]       limit_price;
    logic signed [QtyW-1:0]  quantity;
    logic                    clear_first;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_SHIFT,
    BK_EMIT,
    BK_SCAN,
    BK_CLOSE
  } bk_state_e;

  function automatic logic signed [QtyW-1:0] sat_add(
      input logic signed [QtyW-1:0] a, input logic signed [QtyW-1:0] b);
    logic signed [QtyW:0] s;
    s = {a[QtyW-1], a} + {b[QtyW-1], b};
    if (s[QtyW] != s[QtyW-1])
      return s[QtyW] ? {1'b1, {(QtyW-1){1'b0}}} : {1'b0, {(QtyW-1){1'b1}}};
    return s[QtyW-1:0];
  endfunction

  // a - b, saturated; b may be the most negative value
  function automatic logic signed [QtyW-1:0] sat_sub(
      input logic signed [QtyW-1:0] a, input logic signed [QtyW-1:0] b);
    logic signed [QtyW:0] s;
    s = {a[QtyW-1], a} - {b[QtyW-1], b};
    if (s[QtyW] != s[QtyW-1])
      return s[QtyW] ? {1'b1, {(QtyW-1){1'b0}}} : {1'b0, {(QtyW-1){1'b1}}};
    return s[QtyW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/plob_front.sv @@
// plob_front: two-entry command queue between the input port and the back end.
// Depends on plob_pkg.
`default_nettype none
module plob_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire plob_pkg::cmd_t in_cmd_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output plob_pkg::cmd_t     q_cmd_o
);
  import plob_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count bad");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop empty");
`endif
endmodule
`default_nettype wire

@@ sv/plob_back.sv @@
// plob_back: book storage and command sequencer; one level a cycle unless the result output is stalled.
// Depends on plob_pkg.
`default_nettype none
module plob_back #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [plob_pkg::MinW-1:0]     min_qty_i,
  input  wire logic                          q_valid_i,
  output logic                               q_ready_o,
  input  wire plob_pkg::cmd_t                q_cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         status_o,
  output logic                               found_o,
  output logic [plob_pkg::PriceW-1:0]        level_price_o,
  output logic signed [plob_pkg::QtyW-1:0]   level_size_o,
  output logic                               last_o
);
  import plob_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = $clog2(MaxRes + 1);

  logic [PriceW-1:0]      pr_q [2][DEPTH];
  logic signed [QtyW-1:0] sz_q [2][DEPTH];
  logic [CW-1:0]          cnt_q [2];

  bk_state_e st_q, st_d;
  cmd_t      c_q;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] k_q, k_d;
  logic          hit_q, hit_d;
  logic          pok_q, pok_d;
  logic [RW-1:0] n_q, n_d;
  logic signed [QtyW-1:0] rem_q, rem_d;

  logic          ov_q, ov_d;
  logic [2:0]    os_q, os_d;
  logic          of_q, of_d;
  logic [PriceW-1:0] op_q, op_d;
  logic signed [QtyW-1:0] oz_q, oz_d;
  logic          ol_q, ol_d;

  logic [CW-1:0] ccnt;
  logic [IW-1:0] ii, ij;
  logic [PriceW-1:0] cpr, npr;
  logic signed [QtyW-1:0] csz, ns;
  logic snap, bid, out_free, bef_start, bef_lim, nxt_lim, is_bef, qty_ok, is_last;
  logic signed [QtyW:0] minx;
  logic accept, clr_side;
  logic wr_en, shl, shr, cnt_inc, cnt_dec;
  logic [IW-1:0] wr_i, sh_i;
  logic [PriceW-1:0] wr_p;
  logic signed [QtyW-1:0] wr_s;

  assign bid  = c_q.side;
  assign snap = (c_q.cmd == CMD_SNAP);
  assign ccnt = cnt_q[bid];
  assign ii   = i_q[IW-1:0];
  assign ij   = ii + 1'b1;
  assign cpr  = pr_q[bid][ii];
  assign csz  = sz_q[bid][ii];
  // look-ahead level, only used while the current one is not the last
  assign npr  = pr_q[bid][ij];
  assign minx = {2'b00, min_qty_i};
  assign out_free = !ov_q || out_ready_i;
  assign bef_start = bid ? (cpr > c_q.price) : (cpr < c_q.price);
  assign bef_lim   = bid ? (c_q.limit_price > cpr) : (c_q.limit_price < cpr);
  assign nxt_lim   = bid ? (c_q.limit_price > npr) : (c_q.limit_price < npr);
  assign is_bef    = bid ? (c_q.price > cpr) : (c_q.price < cpr);
  assign qty_ok    = $signed({c_q.quantity[QtyW-1], c_q.quantity}) > minx;
  // on a hit the search stops with i_q on the level
  assign ns = sat_add(csz, c_q.quantity);
  assign q_ready_o = (st_q == BK_IDLE);
  assign accept    = (st_q == BK_IDLE) && q_valid_i;
  assign clr_side  = accept && (q_cmd_i.cmd == CMD_SNAP) && q_cmd_i.clear_first;

  always_comb begin
    st_d = st_q; i_d = i_q; pos_d = pos_q; hit_d = hit_q; pok_d = pok_q;
    n_d = n_q; rem_d = rem_q; k_d = k_q;
    ov_d = ov_q && !out_ready_i;
    os_d = os_q; of_d = of_q; op_d = op_q; oz_d = oz_q; ol_d = ol_q;
    wr_en = 1'b0; wr_i = '0; wr_p = '0; wr_s = '0;
    shl = 1'b0; shr = 1'b0; sh_i = '0;
    cnt_inc = 1'b0; cnt_dec = 1'b0;
    is_last = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        i_d = '0; n_d = '0; hit_d = 1'b0; pok_d = 1'b0; pos_d = '0; k_d = '0;
        if (q_valid_i) begin
          rem_d = q_cmd_i.quantity;
          unique case (q_cmd_i.cmd) inside
            CMD_DELTA, CMD_SNAP, CMD_SIZE: st_d = BK_SEARCH;
            CMD_SWEEP, CMD_RANGE, CMD_LIST: st_d = BK_SCAN;
            default: st_d = BK_EMIT;
          endcase
        end
      end
      BK_SEARCH: begin
        // find the level, note the first slot the price sorts ahead of
        if (i_q >= ccnt) begin
          if (!pok_q) pos_d = i_q;
          k_d = ccnt;
          if (c_q.cmd == CMD_SIZE || (!snap && !qty_ok) || ccnt >= CW'(DEPTH))
            st_d = BK_EMIT;
          else
            st_d = BK_SHIFT;
        end else if (cpr == c_q.price) begin
          hit_d = 1'b1; pos_d = i_q; st_d = BK_EMIT;
        end else begin
          if (!pok_q && is_bef) begin
            pos_d = i_q; pok_d = 1'b1;
          end
          i_d = i_q + 1'b1;
        end
      end
      BK_SHIFT: begin
        // insert: move the tail up one slot per cycle
        if (k_q > pos_q) begin
          shr = 1'b1; sh_i = k_q[IW-1:0]; k_d = k_q - 1'b1;
        end else st_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; ol_d = 1'b1; of_d = 1'b0; op_d = c_q.price; oz_d = '0;
          st_d = BK_IDLE;
          if (c_q.cmd == CMD_SIZE) begin
            os_d = ST_QUERY;
            if (hit_q) begin
              of_d = 1'b1; oz_d = csz;
            end
          end else if (c_q.cmd == CMD_DELTA || c_q.cmd == CMD_SNAP) begin
            if (hit_q) begin
              of_d = 1'b1; oz_d = ns;
              if (!snap && $signed({ns[QtyW-1], ns}) < minx) begin
                // result goes out now, the gap closes afterwards
                os_d = ST_REMOVED; st_d = BK_CLOSE;
              end else begin
                os_d = ST_UPDATED; wr_en = 1'b1; wr_i = ii;
                wr_p = c_q.price; wr_s = ns;
              end
            end else if (!snap && !qty_ok) begin
              os_d = ST_IGNORED;
            end else if (ccnt >= CW'(DEPTH)) begin
              os_d = ST_FULL;
            end else begin
              os_d = ST_INSERTED; of_d = 1'b1; oz_d = c_q.quantity;
              wr_en = 1'b1; wr_i = pos_q[IW-1:0]; wr_p = c_q.price;
              wr_s = c_q.quantity; cnt_inc = 1'b1;
            end
          end else begin
            os_d = ST_IGNORED; op_d = '0;
          end
        end
      end
      BK_SCAN: begin
        // eligible levels form a contiguous run, so the next level decides last
        if (i_q >= ccnt || (c_q.cmd == CMD_RANGE && !bef_start && bef_lim)) begin
          if (out_free) begin
            ov_d = 1'b1; os_d = ST_QUERY; of_d = 1'b0; op_d = '0; oz_d = '0;
            ol_d = 1'b1; st_d = BK_IDLE;
          end
        end else if (c_q.cmd != CMD_LIST && bef_start) begin
          i_d = i_q + 1'b1;
        end else if (out_free) begin
          is_last = (i_q + 1'b1 == ccnt) || (n_q + 1'b1 == RW'(MaxRes));
          if (c_q.cmd == CMD_RANGE && nxt_lim) is_last = 1'b1;
          ov_d = 1'b1; os_d = ST_QUERY; of_d = 1'b1; op_d = cpr; oz_d = csz;
          n_d = n_q + 1'b1; i_d = i_q + 1'b1;
          if (c_q.cmd == CMD_SWEEP) begin
            if (csz < rem_q) rem_d = sat_sub(rem_q, csz);
            else begin
              oz_d = rem_q; is_last = 1'b1;
            end
          end
          ol_d = is_last;
          if (is_last) st_d = BK_IDLE;
        end
      end
      BK_CLOSE: begin
        // removal: pull the tail down one slot per cycle
        if (pos_q + 1'b1 < ccnt) begin
          shl = 1'b1; sh_i = pos_q[IW-1:0]; pos_d = pos_q + 1'b1;
        end else begin
          cnt_dec = 1'b1; st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  assign out_valid_o   = ov_q;
  assign status_o      = os_q;
  assign found_o       = of_q;
  assign level_price_o = op_q;
  assign level_size_o  = oz_q;
  assign last_o        = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; c_q <= '0; cnt_q[0] <= '0; cnt_q[1] <= '0;
      i_q <= '0; n_q <= '0; hit_q <= 1'b0; pok_q <= 1'b0; pos_q <= '0;
      k_q <= '0; rem_q <= '0;
      ov_q <= 1'b0; os_q <= '0; of_q <= 1'b0; op_q <= '0; oz_q <= '0;
      ol_q <= 1'b0;
    end else begin
      st_q <= st_d; i_q <= i_d; n_q <= n_d; hit_q <= hit_d; pok_q <= pok_d;
      pos_q <= pos_d; k_q <= k_d; rem_q <= rem_d;
      ov_q <= ov_d; os_q <= os_d; of_q <= of_d; op_q <= op_d; oz_q <= oz_d;
      ol_q <= ol_d;
      if (accept) c_q <= q_cmd_i;
      if (clr_side) cnt_q[q_cmd_i.side] <= '0;
      else if (cnt_inc) cnt_q[bid] <= ccnt + 1'b1;
      else if (cnt_dec) cnt_q[bid] <= ccnt - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pr_q[bid][wr_i] <= wr_p; sz_q[bid][wr_i] <= wr_s;
    end else if (shr) begin
      pr_q[bid][sh_i] <= pr_q[bid][sh_i - 1'b1];
      sz_q[bid][sh_i] <= sz_q[bid][sh_i - 1'b1];
    end else if (shl) begin
      pr_q[bid][sh_i] <= pr_q[bid][sh_i + 1'b1];
      sz_q[bid][sh_i] <= sz_q[bid][sh_i + 1'b1];
    end
  end

`ifndef SYNTHESIS
  a_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CW'(DEPTH)) else $error("ask count over depth");
  a_cnt_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[1] <= CW'(DEPTH)) else $error("bid count over depth");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RW'(MaxRes)) else $error("too many results");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(oz_q) && $stable(op_q) && $stable(ol_q))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

@@ sv/price_level_order_book_unit.sv @@
// Path: a command waits in the front queue, then enters the back; an update
// searches 1 level/cycle until it hits or runs out, an insert shifts the tail,
// and the result is registered; a removal closes its gap afterwards. Queries
// skip 1 level/cycle, then emit 1 level/cycle unless stalled, last on final.
// Throughput: one command in the back at a time; the 2-entry queue decouples.
// Reset: rst_ni async low clears counts, state and the minimum-size register.
`default_nettype none
module price_level_order_book_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [46:0]  cfg_wdata_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [2:0]   command_i,
  input  wire logic         side_i,
  input  wire logic [31:0]  price_i,
  input  wire logic [31:0]  limit_price_i,
  input  wire logic signed [47:0] quantity_i,
  input  wire logic         clear_first_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [2:0]        status_o,
  output logic              found_o,
  output logic [31:0]       level_price_o,
  output logic signed [47:0] level_size_o,
  output logic              last_o
);
  import plob_pkg::*;

  logic [MinW-1:0] min_qty_q;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_qty_q <= '0;
    else if (cfg_we_i) min_qty_q <= cfg_wdata_i;
  end

  assign in_cmd = '{cmd: command_i, side: side_i, price: price_i,
                    limit_price: limit_price_i, quantity: quantity_i,
                    clear_first: clear_first_i};

  plob_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  plob_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .min_qty_i(min_qty_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .status_o, .found_o, .level_price_o,
    .level_size_o, .last_o
  );

`ifndef SYNTHESIS
  a_last_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> found_o) else $error("non-final empty result");
  a_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_IGNORED || status_o == ST_FULL) |-> !found_o)
    else $error("ignored with level");
  a_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_QUERY && status_o != ST_IGNORED
    && status_o != ST_FULL |-> last_o) else $error("update must be single");
`endif
endmodule
`default_nettype wire

@@ tb/price_level_order_book_unit_tb.sv @@
// Self-checking testbench for price_level_order_book_unit: random and directed
// order book commands, results checked against an in-bench book model.
// Depends on plob_pkg and the unit RTL.
`timescale 1ns / 1ps
module price_level_order_book_unit_tb;
  import plob_pkg::*;

  localparam int Depth = 32;
  localparam int IdleLimit = 20000;
  localparam logic [2:0] CmdBad = 3'd6;    // unused command codes
  localparam logic [2:0] CmdSpare = 3'd7;

  // one pending input transfer
  typedef struct {
    logic [2:0]         cmd;
    logic               side;
    logic [31:0]        price;
    logic [31:0]        limit_price;
    logic signed [47:0] quantity;
    logic               clear_first;
  } book_cmd_t;

  // one result item
  typedef struct {
    logic [2:0]         status;
    logic               found;
    logic [31:0]        price;
    logic signed [47:0] size;
    logic               last;
  } level_res_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [46:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] command;
  logic side, clear_first;
  logic [31:0] price, limit_price;
  logic signed [47:0] quantity;
  logic [2:0] status;
  logic found, last;
  logic [31:0] level_price;
  logic signed [47:0] level_size;

  price_level_order_book_unit #(.DEPTH(Depth)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .side_i(side), .price_i(price),
    .limit_price_i(limit_price), .quantity_i(quantity),
    .clear_first_i(clear_first),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .found_o(found), .level_price_o(level_price),
    .level_size_o(level_size), .last_o(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Book model: side 0 = asks (rising), side 1 = bids (falling).
  // ---------------------------------------------------------------------------
  logic [31:0]        lvl_price [2][Depth];
  logic signed [47:0] lvl_size  [2][Depth];
  int                 lvl_count [2];
  logic [46:0]        min_amt;

  book_cmd_t  pending_cmds[$];
  level_res_t expected_levels[$];
  int         fail_count;

  function automatic logic signed [47:0] clamp_add(logic signed [47:0] a,
                                                   logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -49'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  function automatic logic signed [47:0] clamp_sub(logic signed [47:0] a,
                                                   logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) - 49'(b);
    if (s > 49'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -49'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  // true when price a sorts ahead of b on the side
  function automatic bit ahead(logic s, logic [31:0] a, logic [31:0] b);
    return s ? (a > b) : (a < b);
  endfunction

  function automatic void push_level(logic [2:0] st, logic f, logic [31:0] p,
                                     logic signed [47:0] sz, ref int n);
    level_res_t r;
    if (n >= MaxRes) return;
    r.status = st; r.found = f; r.price = p; r.size = sz; r.last = 1'b0;
    expected_levels.insert(expected_levels.size(), r);
    n++;
  endfunction

  function automatic void apply_update(logic s, logic [31:0] p,
                                       logic signed [47:0] q, bit snap);
    int idx, pos, n;
    logic signed [47:0] ns;
    logic signed [48:0] min_s;
    idx = -1;
    n = 0;
    min_s = {2'b00, min_amt};
    for (int i = 0; i < lvl_count[s]; i++)
      if (idx < 0 && lvl_price[s][i] == p) idx = i;
    if (idx >= 0) begin
      ns = clamp_add(lvl_size[s][idx], q);
      if (!snap && 49'(ns) < min_s) begin
        for (int k = idx; k + 1 < lvl_count[s]; k++) begin
          lvl_price[s][k] = lvl_price[s][k+1];
          lvl_size[s][k] = lvl_size[s][k+1];
        end
        lvl_count[s]--;
        push_level(ST_REMOVED, 1'b1, p, ns, n);
      end else begin
        lvl_size[s][idx] = ns;
        push_level(ST_UPDATED, 1'b1, p, ns, n);
      end
    end else if (!snap && !(49'(q) > min_s)) begin
      push_level(ST_IGNORED, 1'b0, p, '0, n);
    end else if (lvl_count[s] >= Depth) begin
      push_level(ST_FULL, 1'b0, p, '0, n);
    end else begin
      pos = 0;
      while (pos < lvl_count[s] && !ahead(s, p, lvl_price[s][pos])) pos++;
      for (int k = lvl_count[s]; k > pos; k--) begin
        lvl_price[s][k] = lvl_price[s][k-1];
        lvl_size[s][k] = lvl_size[s][k-1];
      end
      lvl_price[s][pos] = p;
      lvl_size[s][pos] = q;
      lvl_count[s]++;
      push_level(ST_INSERTED, 1'b1, p, q, n);
    end
  endfunction

  // works out the results of one accepted command and updates the book
  function automatic void predict_book(book_cmd_t c);
    int n, idx;
    logic s;
    logic signed [47:0] rem;
    s = c.side;
    n = 0;
    case (c.cmd)
      CMD_DELTA: apply_update(s, c.price, c.quantity, 1'b0);
      CMD_SNAP: begin
        if (c.clear_first) lvl_count[s] = 0;
        apply_update(s, c.price, c.quantity, 1'b1);
      end
      CMD_SIZE: begin
        idx = -1;
        for (int i = 0; i < lvl_count[s]; i++)
          if (idx < 0 && lvl_price[s][i] == c.price) idx = i;
        if (idx >= 0) push_level(ST_QUERY, 1'b1, c.price, lvl_size[s][idx], n);
        else push_level(ST_QUERY, 1'b0, c.price, '0, n);
      end
      CMD_SWEEP: begin
        rem = c.quantity;
        for (int i = 0; i < lvl_count[s] && n < MaxRes; i++) begin
          if (ahead(s, lvl_price[s][i], c.price)) continue;
          if (lvl_size[s][i] < rem) begin
            push_level(ST_QUERY, 1'b1, lvl_price[s][i], lvl_size[s][i], n);
            rem = clamp_sub(rem, lvl_size[s][i]);
          end else begin
            push_level(ST_QUERY, 1'b1, lvl_price[s][i], rem, n);
            break;
          end
        end
        if (n == 0) push_level(ST_QUERY, 1'b0, '0, '0, n);
      end
      CMD_RANGE: begin
        for (int i = 0; i < lvl_count[s] && n < MaxRes; i++) begin
          if (ahead(s, lvl_price[s][i], c.price)) continue;
          if (ahead(s, c.limit_price, lvl_price[s][i])) break;
          push_level(ST_QUERY, 1'b1, lvl_price[s][i], lvl_size[s][i], n);
        end
        if (n == 0) push_level(ST_QUERY, 1'b0, '0, '0, n);
      end
      CMD_LIST: begin
        for (int i = 0; i < lvl_count[s] && n < MaxRes; i++)
          push_level(ST_QUERY, 1'b1, lvl_price[s][i], lvl_size[s][i], n);
        if (n == 0) push_level(ST_QUERY, 1'b0, '0, '0, n);
      end
      default: push_level(ST_IGNORED, 1'b0, '0, '0, n);
    endcase
    expected_levels[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, inputs change on the falling edge.
  // ---------------------------------------------------------------------------
  int burst_left, gap_left;

  // transfer flag seen at the last rising edge, used by the falling-edge driver
  logic in_ready_q;
  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready_q) begin
      // previous transfer done (or nothing offered): pick next
      if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        command <= pending_cmds[0].cmd;
        side <= pending_cmds[0].side;
        price <= pending_cmds[0].price;
        limit_price <= pending_cmds[0].limit_price;
        quantity <= pending_cmds[0].quantity;
        clear_first <= pending_cmds[0].clear_first;
        void'(pending_cmds.pop_front());
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern; hold_off forces one long stall to fill the block.
  // ---------------------------------------------------------------------------
  int stall_mode;
  int hold_off;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3, 0) != 0);
        default: out_ready <= 1'($urandom_range(1, 0));
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic book_cmd_t drv_item();
    book_cmd_t c;
    c.cmd = command; c.side = side; c.price = price;
    c.limit_price = limit_price; c.quantity = quantity;
    c.clear_first = clear_first;
    return c;
  endfunction

  int idle_cycles;
  always @(posedge clk) begin
    level_res_t e;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) predict_book(drv_item());
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          $error("result with none expected: status %0d price %0d", status,
                 level_price);
          fail_count++;
        end else begin
          e = expected_levels.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            fail_count++;
          end
          if (found !== e.found) begin
            $error("found: expected %0d actual %0d", e.found, found);
            fail_count++;
          end
          if (level_price !== e.price) begin
            $error("level_price: expected %0d actual %0d", e.price, level_price);
            fail_count++;
          end
          if (level_size !== e.size) begin
            $error("level_size: expected %0d actual %0d", e.size, level_size);
            fail_count++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: long stretches with no transfer at all end the run
  always @(posedge clk) begin
    if (idle_cycles > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [2:0] c, logic s, logic [31:0] p,
                                    logic [31:0] lim, logic signed [47:0] q,
                                    logic clr);
    book_cmd_t b;
    b.cmd = c; b.side = s; b.price = p; b.limit_price = lim;
    b.quantity = q; b.clear_first = clr;
    pending_cmds.insert(pending_cmds.size(), b);
  endfunction

  // prices cluster in a small window so updates hit existing levels
  function automatic logic [31:0] pick_price();
    case ($urandom_range(9, 0))
      0: return 32'hFFFF_FFFF - $urandom_range(3, 0);
      1: return $urandom_range(3, 0);
      2: return $urandom();
      default: return 32'd1000 + $urandom_range(40, 0);
    endcase
  endfunction

  function automatic logic signed [47:0] pick_qty();
    case ($urandom_range(9, 0))
      0: return 48'({$urandom(), $urandom()});
      1: return 48'sh7FFF_FFFF_FFFF - $urandom_range(3, 0);
      2: return 48'sh8000_0000_0000 + $urandom_range(3, 0);
      3: return -$signed(48'($urandom_range(500, 0)));
      default: return 48'($urandom_range(500, 0));
    endcase
  endfunction

  function automatic void queue_random(int count);
    logic [2:0] c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3, 4, 5, 6, 7: c = CMD_DELTA;
        8, 9, 10: c = CMD_SNAP;
        11, 12: c = CMD_SIZE;
        13, 14: c = CMD_SWEEP;
        15, 16: c = CMD_RANGE;
        17: c = CMD_LIST;
        default: c = ($urandom_range(1, 0) == 0) ? CmdBad : CmdSpare;
      endcase
      queue_cmd(c, 1'($urandom_range(1, 0)), pick_price(), pick_price(),
                pick_qty(), ($urandom_range(15, 0) == 0));
    end
  endfunction

  // waits for all results, then a drain pause covering the longest walk
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (4 * Depth + 20) @(posedge clk);
  endtask

  task automatic write_min(logic [46:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    min_amt = v;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    command = '0; side = 1'b0; price = '0; limit_price = '0;
    quantity = '0; clear_first = 1'b0;
    in_ready_q = 1'b0;
    idle_cycles = 0;
    fail_count = 0;
    stall_mode = 0;
    hold_off = 0;
    min_amt = '0;
    lvl_count[0] = 0;
    lvl_count[1] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queries, extremes, every command, unused codes
    queue_cmd(CMD_LIST, 1'b0, '0, '0, '0, 1'b0);
    queue_cmd(CMD_SWEEP, 1'b1, '0, '0, 48'sd10, 1'b0);
    queue_cmd(CMD_RANGE, 1'b0, '0, '1, '0, 1'b0);
    queue_cmd(CMD_SIZE, 1'b0, 32'hFFFF_FFFF, '0, '0, 1'b0);
    queue_cmd(CMD_DELTA, 1'b0, 32'd5, '0, 48'sd0, 1'b0);           // ignored
    queue_cmd(CMD_DELTA, 1'b0, 32'hFFFF_FFFF, '0, 48'sh7FFF_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_DELTA, 1'b0, 32'hFFFF_FFFF, '0, 48'sd5, 1'b0);    // saturate
    queue_cmd(CMD_DELTA, 1'b0, 32'd0, '0, 48'sd7, 1'b0);
    queue_cmd(CMD_DELTA, 1'b1, 32'd100, '0, 48'sd20, 1'b0);
    queue_cmd(CMD_DELTA, 1'b1, 32'd200, '0, 48'sd30, 1'b0);
    queue_cmd(CMD_DELTA, 1'b1, 32'd100, '0, -48'sd25, 1'b0);       // removed
    queue_cmd(CMD_SNAP, 1'b1, 32'd150, '0, 48'sh8000_0000_0000, 1'b0);
    queue_cmd(CMD_SNAP, 1'b1, 32'd150, '0, -48'sd1, 1'b0);         // low saturate
    queue_cmd(CMD_SWEEP, 1'b1, 32'hFFFF_FFFF, '0, 48'sd100, 1'b0);
    queue_cmd(CMD_RANGE, 1'b0, 32'd0, 32'hFFFF_FFFF, '0, 1'b0);
    queue_cmd(CMD_SIZE, 1'b1, 32'd200, '0, '0, 1'b0);
    queue_cmd(CMD_LIST, 1'b1, '0, '0, '0, 1'b0);
    queue_cmd(CmdBad, 1'b0, '1, '1, '1, 1'b1);
    queue_cmd(CmdSpare, 1'b1, '0, '0, '0, 1'b0);
    queue_cmd(CMD_SNAP, 1'b0, 32'd42, '0, 48'sd3, 1'b1);           // clear side
    queue_cmd(CMD_LIST, 1'b0, '0, '0, '0, 1'b0);
    drain();

    // fill the ask side past full while the receiver holds off
    write_min(47'd0);
    stall_mode = 1;
    hold_off = 300;
    for (int i = 0; i < Depth + 2; i++)
      queue_cmd(CMD_DELTA, 1'b0, 32'(2000 + 3 * i), '0, 48'(1 + i), 1'b0);
    queue_cmd(CMD_LIST, 1'b0, '0, '0, '0, 1'b0);
    queue_cmd(CMD_SWEEP, 1'b0, 32'd2010, '0, 48'sd40, 1'b0);
    queue_cmd(CMD_RANGE, 1'b0, 32'd2010, 32'd2050, '0, 1'b0);
    drain();

    // random phases across min_amt settings and stall modes
    write_min(47'd100);
    stall_mode = 2;
    queue_random(20);
    drain();
    write_min(47'h7FFF_FFFF_FFFF);
    stall_mode = 0;
    queue_random(10);
    drain();
    write_min(47'($urandom_range(300, 0)));
    stall_mode = 1;
    queue_random(22);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
